// ===== sv/bnb_pkg.sv =====
// Package for the batch-norm backward block: field widths, action and
// register codes, and the item types shared between the modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bnb_pkg;

   localparam int ACTION_W  = 2;
   localparam int ROW_W     = 6;
   localparam int COL_W     = 6;
   localparam int VAL_W     = 16;
   localparam int INVDEV_W  = 15;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;
   localparam int GSUM_W    = 40;
   localparam int GNSUM_W   = 48;
   localparam int GRAD_W    = 32;

   localparam logic [ACTION_W-1:0] ACT_SET  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_LOAD = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_ROWS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEATURE_COLS = 2'd1;

   localparam logic [CFG_W-1:0] BATCH_ROWS_RST   = 7'd64;
   localparam logic [CFG_W-1:0] FEATURE_COLS_RST = 7'd64;

   typedef struct packed {
      logic [ACTION_W-1:0]    action;
      logic [ROW_W-1:0]       row;
      logic [COL_W-1:0]       column;
      logic signed [VAL_W-1:0] grad_in;
      logic signed [VAL_W-1:0] norm_in;
      logic signed [VAL_W-1:0] scale_in;
      logic [INVDEV_W-1:0]    inv_dev_in;
   } bnb_req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] grad_out;
      logic [ROW_W-1:0]        out_row;
      logic [COL_W-1:0]        out_col;
      logic                    clipped;
   } bnb_rsp_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic        valid;
      bnb_req_type item;
   } bnb_queue_type;

endpackage

`default_nettype wire

// ===== sv/batch_norm_backward_top.sv =====
// Top level of the batch-norm backward block: joins the front end and the
// back end. Depends on bnb_pkg, bnb_front and bnb_back.
//
// Usage: items arrive on req_valid / req_stall / req_data and are taken at an
// edge with req_valid high and req_stall low. Action 0 sets up a column,
// action 1 loads an element into the column sums, action 2 reads one input
// gradient, which leaves on rsp_valid / rsp_stall / rsp_data. Registers
// batch_rows (index 0) and feature_cols (index 1) are written through
// csr_valid / csr_index / csr_wdata, ready except in reset; the user must write them
// only while the block is idle; the block itself does not enforce this. A column setup
// passes through state SET, an element load through FETCH and L1 to L3, and a read
// through FETCH, the multiply chain R1 to R3, R4, the radix-16 divider and DONE to the
// result register. One item is worked at a time; a two-entry queue takes items while
// the back end works; items with no effect are taken like any other and dropped.
// Reset clears the registers to 64, empties the queue and marks every column
// sum as zero; req_stall is high during reset. When the receiver stalls, the
// result holds in its register and the back end waits before delivering the next one.
`timescale 1ns / 1ps
`default_nettype none

module batch_norm_backward_top
   import bnb_pkg::*;
#(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int FRAC_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire bnb_req_type          req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      bnb_rsp_type          rsp_data,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   bnb_queue_type    q_head;
   logic             q_pop;
   logic [CFG_W-1:0] batch_n;

   // Accept, filter and queue items.
   bnb_front #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .batch_n   (batch_n)
   );

   // Execute queued items.
   bnb_back #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .batch_n   (batch_n),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== sv/bnb_front.sv =====
// Front end: configuration registers, item filtering and a two-entry
// command queue toward the back end. Depends on bnb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bnb_front
   import bnb_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire bnb_req_type          req_data,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata,
   output      bnb_queue_type        q_head,
   input  wire logic                 q_pop,
   output      logic [CFG_W-1:0]     batch_n
);

   logic [CFG_W-1:0] rows_ff, rows_in;
   logic [CFG_W-1:0] cols_ff, cols_in;

   bnb_req_type q_mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   logic accept, keep, push;

   // Writes are taken on any cycle outside reset.
   assign csr_ready = !reset;

   // Register writes.
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid) begin
         if (csr_index == CSR_BATCH_ROWS) rows_in = csr_wdata;
         if (csr_index == CSR_FEATURE_COLS) cols_in = csr_wdata;
      end
   end

   // A zero row count gives a batch size of one.
   assign batch_n = (rows_ff == '0) ? CFG_W'(1) : rows_ff;

   // Decide whether an item has any effect.
   always_comb begin
      keep = 1'b1;
      if ({1'b0, req_data.column} >= cols_ff || 32'(req_data.column) >= MAX_COLS)
         keep = 1'b0;
      else if (req_data.action != ACT_SET) begin
         if (req_data.action != ACT_LOAD && req_data.action != ACT_READ)
            keep = 1'b0;
         else if ({1'b0, req_data.row} >= rows_ff || 32'(req_data.row) >= MAX_ROWS)
            keep = 1'b0;
      end
   end

   // Hold off items while the queue is full or the block is in reset.
   assign req_stall = reset || (count_ff == 2'd2);
   assign accept    = req_valid && !req_stall;
   assign push      = accept && keep;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.item  = q_mem_ff[rd_ptr_ff];

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) q_mem_ff[wr_ptr_ff] <= req_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= BATCH_ROWS_RST;
         cols_ff   <= FEATURE_COLS_RST;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rows_ff   <= rows_in;
         cols_ff   <= cols_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/bnb_back.sv =====
// Back end: column and element memories, column sums, the arithmetic
// sequencer with its radix-16 divider, and the result register. Depends on bnb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bnb_back
   import bnb_pkg::*;
#(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int FRAC_BITS = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire bnb_queue_type    q_head,
   output      logic             q_pop,
   input  wire logic [CFG_W-1:0] batch_n,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      bnb_rsp_type      rsp_data
);

   localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int EW    = $clog2(DEPTH);
   localparam int TW    = 49;
   localparam int PW    = 64;
   localparam int QW    = 20;
   localparam int DSTEP = 4;
   localparam int DITER = QW / DSTEP;
   localparam int XW    = VAL_W + GNSUM_W;
   localparam int WW    = GNSUM_W + 18;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SET   = 4'd1;
   localparam logic [3:0] ST_FETCH = 4'd2;
   localparam logic [3:0] ST_L1    = 4'd3;
   localparam logic [3:0] ST_L2    = 4'd4;
   localparam logic [3:0] ST_L3    = 4'd5;
   localparam logic [3:0] ST_R1    = 4'd6;
   localparam logic [3:0] ST_R2    = 4'd7;
   localparam logic [3:0] ST_R3    = 4'd8;
   localparam logic [3:0] ST_R4    = 4'd9;
   localparam logic [3:0] ST_DIV   = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0]  state_ff, state_in;
   bnb_req_type cmd_ff;
   logic [2:0]  iter_ff, iter_in;

   // Memories and their registered read data.
   logic signed [VAL_W-1:0]   scale_mem [MAX_COLS];
   logic [INVDEV_W-1:0]       inv_mem   [MAX_COLS];
   logic signed [GSUM_W-1:0]  gsum_mem  [MAX_COLS];
   logic signed [GNSUM_W-1:0] gnsum_mem [MAX_COLS];
   logic signed [GRAD_W-1:0]  g_mem     [DEPTH];
   logic signed [VAL_W-1:0]   xh_mem    [DEPTH];

   logic signed [VAL_W-1:0]   scale_rd_ff;
   logic [INVDEV_W-1:0]       inv_rd_ff;
   logic signed [GSUM_W-1:0]  gsum_rd_ff;
   logic signed [GNSUM_W-1:0] gnsum_rd_ff;
   logic signed [GRAD_W-1:0]  g_rd_ff;
   logic signed [VAL_W-1:0]   xh_rd_ff;
   logic [MAX_COLS-1:0]       sum_vld_ff;

   logic [CW-1:0] col_addr;
   logic [EW-1:0] elem_addr;
   logic [31:0]   elem_full;
   logic [31:0]   col_full;

   logic signed [GSUM_W-1:0]  s1;
   logic signed [GNSUM_W-1:0] s2;

   // Datapath registers.
   logic signed [GRAD_W-1:0]  g_ff;
   logic signed [GNSUM_W-1:0] gx_ff;
   logic signed [GSUM_W-1:0]  gn_ff;
   logic signed [XW-1:0]      xs_ff;
   logic signed [GSUM_W-1:0]  s1_ff;
   logic signed [TW-1:0]      t_ff;
   logic signed [PW-1:0]      p_ff;
   logic                      neg_ff, ovf_ff;
   logic [6:0]                rem_ff, rem_in;
   logic [QW-1:0]             dvd_ff, dvd_in;
   logic [QW-1:0]             quo_ff, quo_in;

   logic signed [XW-1:0]      gxh_full;
   logic signed [WW-1:0]      t_wide;
   logic signed [TW-1:0]      t_clamp;
   logic [PW-1:0]             mag, mag_sh;
   logic [PW-QW-1:0]          mag_hi;

   logic                      rsp_valid_ff, rsp_valid_in;
   bnb_rsp_type               rsp_ff, rsp_res;
   logic                      out_free;

   assign col_full  = 32'(cmd_ff.column);
   assign col_addr  = col_full[CW-1:0];
   assign elem_full = 32'(cmd_ff.row) * 32'(MAX_COLS) + 32'(cmd_ff.column);
   assign elem_addr = elem_full[EW-1:0];

   // Column sums read as zero until the column is set up.
   assign s1 = sum_vld_ff[col_addr] ? gsum_rd_ff : '0;
   assign s2 = sum_vld_ff[col_addr] ? gnsum_rd_ff : '0;

   // Memory reads follow the current command.
   always_ff @(posedge clock) begin
      scale_rd_ff <= scale_mem[col_addr];
      inv_rd_ff   <= inv_mem[col_addr];
      gsum_rd_ff  <= gsum_mem[col_addr];
      gnsum_rd_ff <= gnsum_mem[col_addr];
      g_rd_ff     <= g_mem[elem_addr];
      xh_rd_ff    <= xh_mem[elem_addr];
   end

   // Memory writes: column setup and element load.
   always_ff @(posedge clock) begin
      if (state_ff == ST_SET) begin
         scale_mem[col_addr] <= cmd_ff.scale_in;
         inv_mem[col_addr]   <= cmd_ff.inv_dev_in;
         gsum_mem[col_addr]  <= '0;
         gnsum_mem[col_addr] <= '0;
      end else if (state_ff == ST_L3) begin
         gsum_mem[col_addr]  <= s1 + GSUM_W'(g_ff);
         gnsum_mem[col_addr] <= s2 + gx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_L3) begin
         g_mem[elem_addr]  <= g_ff;
         xh_mem[elem_addr] <= cmd_ff.norm_in;
      end
   end

   // Element and read arithmetic.
   assign gxh_full = XW'(g_ff) * XW'(cmd_ff.norm_in);

   always_comb begin
      t_wide = WW'(gn_ff) - WW'(s1_ff) - WW'(xs_ff >>> FRAC_BITS);
      if (t_wide > (WW'(1) <<< 47))
         t_clamp = TW'(1) <<< 47;
      else if (t_wide < -(WW'(1) <<< 47))
         t_clamp = -(TW'(1) <<< 47);
      else
         t_clamp = t_wide[TW-1:0];
   end

   assign mag    = p_ff[PW-1] ? PW'(-p_ff) : PW'(p_ff);
   assign mag_sh = mag >> (2 * FRAC_BITS);
   assign mag_hi = mag_sh[PW-1:QW];

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_L1: g_ff <= GRAD_W'($signed(cmd_ff.grad_in) * $signed(scale_rd_ff));
         ST_L2: gx_ff <= GNSUM_W'(gxh_full >>> FRAC_BITS);
         ST_R1: begin
            gn_ff <= GSUM_W'($signed(g_rd_ff) * $signed({1'b0, batch_n}));
            xs_ff <= XW'($signed(xh_rd_ff) * $signed(s2));
            s1_ff <= s1;
         end
         ST_R2: t_ff <= t_clamp;
         ST_R3: p_ff <= PW'(t_ff) * PW'($signed({1'b0, inv_rd_ff}));
         ST_R4: begin
            neg_ff <= p_ff[PW-1];
            ovf_ff <= (mag_hi >= (PW-QW)'(batch_n));
         end
         default: ;
      endcase
   end

   // Restoring divider, four quotient bits per cycle.
   always_comb begin
      logic [7:0]    r8;
      logic [6:0]    r;
      logic [QW-1:0] d;
      logic [QW-1:0] q;
      r8 = '0;
      r = rem_ff;
      d = dvd_ff;
      q = quo_ff;
      if (state_ff == ST_R4) begin
         r = mag_hi[6:0];
         d = mag_sh[QW-1:0];
         q = '0;
      end else if (state_ff == ST_DIV) begin
         for (int k = 0; k < DSTEP; k++) begin
            r8 = {r, d[QW-1]};
            d  = {d[QW-2:0], 1'b0};
            if (r8 >= {1'b0, batch_n}) begin
               r8 = r8 - {1'b0, batch_n};
               q  = {q[QW-2:0], 1'b1};
            end else begin
               q  = {q[QW-2:0], 1'b0};
            end
            r = r8[6:0];
         end
      end
      rem_in = r;
      dvd_in = d;
      quo_in = q;
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   // Saturate the quotient and apply the sign.
   always_comb begin
      rsp_res.out_row = cmd_ff.row;
      rsp_res.out_col = cmd_ff.column;
      rsp_res.clipped = 1'b0;
      if (!neg_ff) begin
         if (ovf_ff || quo_ff > QW'(32767)) begin
            rsp_res.grad_out = 16'sh7fff;
            rsp_res.clipped  = 1'b1;
         end else begin
            rsp_res.grad_out = quo_ff[VAL_W-1:0];
         end
      end else begin
         if (ovf_ff || quo_ff > QW'(32768)) begin
            rsp_res.grad_out = 16'sh8000;
            rsp_res.clipped  = 1'b1;
         end else begin
            rsp_res.grad_out = VAL_W'(-quo_ff);
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      q_pop    = 1'b0;
      rsp_valid_in = (rsp_valid_ff && rsp_stall);
      unique case (state_ff)
         ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               state_in = (q_head.item.action == ACT_SET) ? ST_SET : ST_FETCH;
            end
         end
         ST_SET:   state_in = ST_IDLE;
         ST_FETCH: state_in = (cmd_ff.action == ACT_LOAD) ? ST_L1 : ST_R1;
         ST_L1:    state_in = ST_L2;
         ST_L2:    state_in = ST_L3;
         ST_L3:    state_in = ST_IDLE;
         ST_R1:    state_in = ST_R2;
         ST_R2:    state_in = ST_R3;
         ST_R3:    state_in = ST_R4;
         ST_R4: begin
            iter_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            iter_in = iter_ff + 3'd1;
            if (iter_ff == 3'(DITER - 1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) cmd_ff <= q_head.item;
      if (state_ff == ST_DONE && out_free) rsp_ff <= rsp_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         sum_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_SET) sum_vld_ff[col_addr] <= 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
